// ===== rtl/rcw_pkg.sv =====
// Package for the RIFF chunk walker: payload types, status codes, ID classification.
`default_nettype none
package rcw_pkg;

  // Default width of the file offset counters
  localparam int RCW_OFFSET_BITS = 32;

  localparam int RCW_NUM_KINDS = 10;
  localparam int RCW_SUM_BITS  = 11;
  localparam int RCW_KIND_BITS = 4;

  // Signed byte sums of the recognized chunk IDs, indexed by kind
  localparam logic [RCW_SUM_BITS-1:0] KIND_SUM [RCW_NUM_KINDS] = '{
    11'd295, 11'd359, 11'd410, 11'd444, 11'd446,
    11'd308, 11'd300, 11'd312, 11'd299, 11'd318
  };

  // Kind of the RIFF container chunk
  localparam logic [RCW_KIND_BITS-1:0] KIND_RIFF = 4'd0;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_RIFF   = 2'd1,
    STATUS_UNKNOWN_ID = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } rcw_in_t;

  typedef struct packed {
    logic [RCW_KIND_BITS-1:0] chunk_kind;
    logic [31:0]              chunk_offset;
    logic [31:0]              chunk_length;
    status_t                  status;
  } rcw_out_t;

  typedef struct packed {
    logic                     hit;
    logic [RCW_KIND_BITS-1:0] kind;
  } rcw_class_t;

  // Match an ID sum against the table; the lowest-indexed match wins, kind 0 on a miss
  function automatic rcw_class_t rcw_classify(input logic [RCW_SUM_BITS-1:0] sum);
    rcw_class_t c;
    c.hit  = 1'b0;
    c.kind = KIND_RIFF;
    for (int k = RCW_NUM_KINDS - 1; k >= 0; k--) begin
      if (KIND_SUM[k] == sum) begin
        c.hit  = 1'b1;
        c.kind = RCW_KIND_BITS'(k);
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rcw_stream_if.sv =====
// Valid/ready stream interface carrying one payload item per handshake.
`default_nettype none
interface rcw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/riff_chunk_walker_core.sv =====
// RIFF chunk walker top level: byte input, header walker, output register with skid.
// A header result is registered into the output or skid stage with its last size byte.
// Throughput: one byte per cycle while input ready is high; state updates once per byte.
// Input ready drops only while both the output register and the skid stage hold results.
// Reset (rst, synchronous, active high) clears the walker state and empties the output.
`default_nettype none
module riff_chunk_walker_core import rcw_pkg::*; #(
  parameter int OFFSET_BITS = RCW_OFFSET_BITS
) (
  input wire logic      clk,
  input wire logic      rst,
  rcw_stream_if.sink    in_ch,
  rcw_stream_if.source  out_ch
);

  logic     accept;
  logic     res_valid;
  rcw_out_t res;

  logic     out_valid;
  rcw_out_t out_data;
  logic     skid_valid;
  rcw_out_t skid_data;
  logic     out_take;

  assign in_ch.ready   = !skid_valid;
  assign accept        = in_ch.valid && !skid_valid;
  assign out_take      = out_valid && out_ch.ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.payload = out_data;

  rcw_header_walker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_ch.payload),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (accept && res_valid) begin
      if (out_valid && !out_take) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcw_header_walker.sv =====
// Header walker: per-byte state update and result formation for the chunk parser.
`default_nettype none
module rcw_header_walker import rcw_pkg::*; #(
  parameter int OFFSET_BITS = RCW_OFFSET_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire rcw_in_t    item,
  output      logic       res_valid,
  output      rcw_out_t   res
);

  logic [2:0]              header_phase, header_phase_next;
  logic [RCW_SUM_BITS-1:0] id_sum, id_sum_next;
  logic [31:0]             size_shift, size_shift_next;
  logic [32:0]             skip_remaining, skip_remaining_next;
  logic [OFFSET_BITS-1:0]  byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0]  header_start, header_start_next;
  logic                    past_first_chunk, past_first_chunk_next;
  logic                    halted, halted_next;

  logic [RCW_SUM_BITS-1:0] byte_sx;
  logic [31:0]             size_full;
  rcw_class_t              cls;

  assign byte_sx   = {{(RCW_SUM_BITS-8){item.data_byte[7]}}, item.data_byte};
  assign size_full = size_shift | {item.data_byte, 24'd0};
  assign cls       = rcw_classify(id_sum);

  // Next state and result for the byte on the input
  always_comb begin
    header_phase_next     = header_phase;
    id_sum_next           = id_sum;
    size_shift_next       = size_shift;
    skip_remaining_next   = skip_remaining;
    header_start_next     = header_start;
    past_first_chunk_next = past_first_chunk;
    halted_next           = halted;
    byte_position_next    = byte_position + 1'b1;
    res_valid             = 1'b0;
    res.chunk_kind        = cls.kind;
    res.chunk_offset      = 32'(header_start);
    res.chunk_length      = size_full;
    res.status            = STATUS_OK;

    if (halted) begin
      // drop bytes until end of file
    end else if (skip_remaining != 33'd0) begin
      skip_remaining_next = skip_remaining - 33'd1;
    end else if (!header_phase[2]) begin
      // ID bytes: running signed sum
      if (header_phase == 3'd0) begin
        header_start_next = byte_position;
        id_sum_next       = byte_sx;
      end else begin
        id_sum_next = id_sum + byte_sx;
      end
      header_phase_next = header_phase + 3'd1;
    end else begin
      // size bytes, little-endian
      header_phase_next = header_phase + 3'd1;
      unique case (header_phase[1:0])
        2'd0: size_shift_next = {24'd0, item.data_byte};
        2'd1: size_shift_next = size_shift | {16'd0, item.data_byte, 8'd0};
        2'd2: size_shift_next = size_shift | {8'd0, item.data_byte, 16'd0};
        2'd3: begin
          size_shift_next = size_full;
          res_valid       = 1'b1;
          if (!cls.hit) begin
            res.status  = STATUS_UNKNOWN_ID;
            halted_next = 1'b1;
          end else if (!past_first_chunk) begin
            if (cls.kind != KIND_RIFF) begin
              res.status  = STATUS_NOT_RIFF;
              halted_next = 1'b1;
            end else begin
              past_first_chunk_next = 1'b1;
              skip_remaining_next   = 33'd4;
            end
          end else begin
            skip_remaining_next = {1'b0, size_full} + {32'd0, size_full[0]};
          end
        end
        default: ;
      endcase
    end

    // End of file rearms the walker after this byte
    if (item.end_of_file) begin
      header_phase_next     = '0;
      id_sum_next           = '0;
      size_shift_next       = '0;
      skip_remaining_next   = '0;
      byte_position_next    = '0;
      header_start_next     = '0;
      past_first_chunk_next = 1'b0;
      halted_next           = 1'b0;
    end
  end

  // Walker state, updated once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      header_phase     <= '0;
      id_sum           <= '0;
      size_shift       <= '0;
      skip_remaining   <= '0;
      byte_position    <= '0;
      header_start     <= '0;
      past_first_chunk <= 1'b0;
      halted           <= 1'b0;
    end else if (accept) begin
      header_phase     <= header_phase_next;
      id_sum           <= id_sum_next;
      size_shift       <= size_shift_next;
      skip_remaining   <= skip_remaining_next;
      byte_position    <= byte_position_next;
      header_start     <= header_start_next;
      past_first_chunk <= past_first_chunk_next;
      halted           <= halted_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcw_checker.sv =====
// Port-level checks for the RIFF chunk walker, bound to the top level.
`default_nettype none
module rcw_checker import rcw_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire rcw_out_t    out_payload
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // Backpressure on the input only while a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Output is empty and input ready is high on the first cycle out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && in_ready)
    else $error("output not empty after reset");

  // Unknown IDs report kind zero; other results name a table kind
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_payload.status == STATUS_UNKNOWN_ID && out_payload.chunk_kind == KIND_RIFF)
      || ((out_payload.status == STATUS_OK || out_payload.status == STATUS_NOT_RIFF)
          && out_payload.chunk_kind < 4'(RCW_NUM_KINDS)))
    else $error("bad kind or status on result");

  // A first-chunk error never names RIFF
  a_not_riff: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.status == STATUS_NOT_RIFF |-> out_payload.chunk_kind != KIND_RIFF)
    else $error("not-RIFF status with RIFF kind");

endmodule

bind riff_chunk_walker_core rcw_checker u_rcw_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);
`default_nettype wire
